### sv/semaphore_with_wait_queue_unit_assert.svh
// Assertion macros for the semaphore wait queue unit.
`ifndef SEMAPHORE_WITH_WAIT_QUEUE_UNIT_ASSERT_SVH
`define SEMAPHORE_WITH_WAIT_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define SWQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swq assertion failed");

// Next-cycle implication, clocked on i_clk, off while in reset.
`define SWQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swq assertion failed");

`endif

### sv/swq_pkg.sv
// Shared types and constants for the semaphore wait queue unit.
`timescale 1ns / 1ps
package swq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W       = PTR_W + 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int COUNT_W     = 8;
    localparam int INIT_W      = 7;

    localparam logic [INIT_W-1:0]         INIT_COUNT_RST = 7'd1;
    localparam logic signed [COUNT_W-1:0] COUNT_MAX      = 8'sd127;
    localparam logic signed [COUNT_W-1:0] COUNT_NEG_ONE  = -8'sd1;

    typedef enum logic {
        OP_WAIT   = 1'b0,
        OP_SIGNAL = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_SUSPEND = 2'd1,
        ACT_RESUME  = 2'd2
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // Update decided for one request.
    typedef struct packed {
        logic signed [COUNT_W-1:0] count;
        logic [FILL_W-1:0]         fill;
        logic [PTR_W-1:0]          head;
        logic [PTR_W-1:0]          tail;
        logic                      enq;
        logic                      deq;
        t_action                   action;
        logic                      dropped;
    } t_decision;

endpackage

### sv/swq_ctrl.sv
// Request decode: count update and queue pointer moves for one request.
`timescale 1ns / 1ps
module swq_ctrl (
    input  logic                               i_opcode,
    input  logic signed [swq_pkg::COUNT_W-1:0] i_count,
    input  logic [swq_pkg::FILL_W-1:0]         i_fill,
    input  logic [swq_pkg::PTR_W-1:0]          i_head,
    output swq_pkg::t_decision                 o_dec
);
    import swq_pkg::*;

    logic [SUM_W-1:0] w_sum;

    always_comb begin
        w_sum = SUM_W'(i_head) + SUM_W'(i_fill);
        if (w_sum >= SUM_W'(QUEUE_DEPTH)) begin
            w_sum = w_sum - SUM_W'(QUEUE_DEPTH);
        end
    end

    always_comb begin
        o_dec         = '0;
        o_dec.count   = i_count;
        o_dec.fill    = i_fill;
        o_dec.head    = i_head;
        o_dec.tail    = w_sum[PTR_W-1:0];
        o_dec.action  = ACT_NONE;
        if (i_opcode == OP_WAIT) begin
            if (!i_count[COUNT_W-1]) begin
                o_dec.count = i_count - COUNT_W'(1);
            end
            if (o_dec.count == COUNT_NEG_ONE) begin
                o_dec.action = ACT_SUSPEND;
                if (i_fill < FILL_W'(QUEUE_DEPTH)) begin
                    o_dec.enq  = 1'b1;
                    o_dec.fill = i_fill + FILL_W'(1);
                end else begin
                    o_dec.dropped = 1'b1;
                end
            end
        end else begin
            if (i_count != COUNT_MAX) begin
                o_dec.count = i_count + COUNT_W'(1);
            end
            if (!o_dec.count[COUNT_W-1] && (i_fill != '0)) begin
                o_dec.action = ACT_RESUME;
                o_dec.deq    = 1'b1;
                o_dec.fill   = i_fill - FILL_W'(1);
                o_dec.head   = (i_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i_head + PTR_W'(1);
            end
        end
    end

endmodule

### sv/semaphore_with_wait_queue_unit.sv
// Latency: result registered, valid the cycle after accept; a resuming signal also
// passes the registered read of the wait queue memory (ST_READ).
// Throughput: one request per cycle unless the output is stalled; none during ST_READ.
// Reset: count loads 1, queue empty; queue memory needs no clearing pass.
// A config write reloads the count and empties the queue.
`timescale 1ns / 1ps
module semaphore_with_wait_queue_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [swq_pkg::INIT_W-1:0]         i_cfg_initial_count,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_opcode,
    input  logic [swq_pkg::ID_BITS-1:0]        i_requester_id,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_action,
    output logic [swq_pkg::ID_BITS-1:0]        o_resumed_id,
    output logic                               o_dropped,
    output logic signed [swq_pkg::COUNT_W-1:0] o_count_after,
    output logic [swq_pkg::FILL_W-1:0]         o_waiting
);
    import swq_pkg::*;

    `include "semaphore_with_wait_queue_unit_assert.svh"

    t_state                    r_state, n_state;
    logic signed [COUNT_W-1:0] r_count;
    logic [FILL_W-1:0]         r_fill;
    logic [PTR_W-1:0]          r_head;
    logic                      r_out_valid;
    t_action                   r_out_action;
    logic                      r_out_dropped;
    logic [ID_BITS-1:0]        r_rd_data;
    logic [ID_BITS-1:0]        r_mem [QUEUE_DEPTH];

    t_decision w_dec;
    logic      w_accept;
    logic      w_cfg_wr;
    logic      w_rd_en;

    swq_ctrl u_ctrl (
        .i_opcode (i_opcode),
        .i_count  (r_count),
        .i_fill   (r_fill),
        .i_head   (r_head),
        .o_dec    (w_dec)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_dec.deq) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Output register may be refilled in the cycle its beat is taken.
    always_comb begin
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = !r_out_valid || i_ready;
            ST_READ: o_ready = 1'b0;
            default: o_ready = 1'b0;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_accept    = i_valid && o_ready;
    assign w_rd_en     = w_accept && w_dec.deq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= COUNT_W'(INIT_COUNT_RST);
            r_fill      <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_count <= COUNT_W'(i_cfg_initial_count);
                r_fill  <= '0;
                r_head  <= '0;
            end else if (w_accept) begin
                r_count <= w_dec.count;
                r_fill  <= w_dec.fill;
                r_head  <= w_dec.head;
            end
            if (w_accept) begin
                r_out_valid <= !w_dec.deq;
            end else if (r_state == ST_READ) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_action  <= w_dec.action;
            r_out_dropped <= w_dec.dropped;
        end
    end

    // Queue memory: one write port at the tail, one registered read at the head.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_dec.enq) begin
            r_mem[w_dec.tail] <= i_requester_id;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_action      = r_out_action;
    assign o_resumed_id  = (r_out_action == ACT_RESUME) ? r_rd_data : '0;
    assign o_dropped     = r_out_dropped;
    assign o_count_after = r_count;
    assign o_waiting     = r_fill;

    `SWQ_ASSERT_IMP(a_count_floor, 1'b1, r_count >= COUNT_NEG_ONE)
    `SWQ_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= FILL_W'(QUEUE_DEPTH))
    `SWQ_ASSERT_NXT(a_read_then_out, r_state == ST_READ, r_out_valid && (r_state == ST_IDLE))
    `SWQ_ASSERT_NXT(a_deq_reads, w_rd_en && !w_cfg_wr, (r_state == ST_READ) && !r_out_valid)

endmodule
